// ===== src/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, operation codes and status codes.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] z_re;
    logic signed [31:0] z_im;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ===== src/complex_arith_unit_top.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Q16.16 complex add, subtract, multiply and divide with saturation.
// ----------------------------------------------------------------------------
// Usage: present an item on in_data with in_valid; it is taken at an edge
// where in_stall is low. The result item appears on out_data with out_valid
// and is taken at an edge where out_stall is low.
// Throughput is one item per cycle while the output is not stalled. Every
// operation takes the same path from acceptance to out_valid: the input
// queue, registers for products, sums and the divide overflow test, and 33
// stages of the pipelined restoring divider, one quotient bit per stage, the
// last of which feeds the output register. All items pass through in order.
// While out_valid and out_stall are both high the whole back pipeline holds;
// the two-entry input queue fills and then raises in_stall.
// Reset empties the queue and the pipeline; no result is pending after it.
// ----------------------------------------------------------------------------
module complex_arith_unit_top import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     q_valid, q_pop;
  in_item_t q_data;

  cau_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  cau_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== src/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts items and holds them in a short queue.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output in_item_t q_data
);

  localparam int Depth = 2;

  in_item_t   mem_r [Depth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // Queue control: accept while there is a free slot.
  assign in_stall = (cnt_r == 2'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage of queued items.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(Depth)) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(Depth)) |-> in_stall) else $error("full queue not stalling");
`endif

endmodule

// ===== src/cau_back.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Pipelined add/sub, multiply, restoring divide and saturation with an output stage.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  in_item_t  q_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Quotient magnitude: numerator < 2^81, divisor >= 1; 83 steps suffice,
  // a result >= 2^32 saturates anyway, so only 33 quotient bits are formed
  // after a magnitude overflow test.
  localparam int NW = 82;          // numerator magnitude width
  localparam int DW = 65;          // divisor width
  localparam int QB = 33;          // quotient bits kept
  localparam int NS = QB + 2;      // total stages

  typedef struct packed {
    logic              vld;
    logic [1:0]        func;
    logic signed [66:0] sr;        // add/sub/mul result or unused
    logic signed [66:0] si;
    logic [NW-1:0]     nr, ni;     // remainder-numerator regs
    logic [QB-1:0]     qr, qi;
    logic              ngr, ngi;
    logic              ovr, ovi;
    logic [DW-1:0]     d;
  } st_t;

  st_t s_r [NS];
  logic adv;

  // Whole pipe moves when the output is free.
  assign adv   = !(out_valid && out_stall);
  assign q_pop = q_valid && adv;

  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  assign p_rr = q_data.a_re * q_data.b_re;
  assign p_ii = q_data.a_im * q_data.b_im;
  assign p_ri = q_data.a_re * q_data.b_im;
  assign p_ir = q_data.a_im * q_data.b_re;

  // Stage 0: products (one 32x32 multiplier each).
  logic signed [63:0] m0_rr, m0_ii, m0_ri, m0_ir, m0_bb, m0_cc;
  logic [1:0] m0_f;
  logic signed [32:0] m0_ar, m0_ai;
  logic m0_v;
  always_ff @(posedge clk) begin
    if (!rst_n) m0_v <= 1'b0;
    else if (adv) m0_v <= q_pop;
    if (adv) begin
      m0_f  <= q_data.func;
      m0_rr <= p_rr; m0_ii <= p_ii; m0_ri <= p_ri; m0_ir <= p_ir;
      m0_bb <= q_data.b_re * q_data.b_re;
      m0_cc <= q_data.b_im * q_data.b_im;
      if (q_data.func == FUNC_ADD) begin
        m0_ar <= 33'(q_data.a_re) + 33'(q_data.b_re);
        m0_ai <= 33'(q_data.a_im) + 33'(q_data.b_im);
      end else begin
        m0_ar <= 33'(q_data.a_re) - 33'(q_data.b_re);
        m0_ai <= 33'(q_data.a_im) - 33'(q_data.b_im);
      end
    end
  end

  // Stage 1: sums, numerators, magnitude and divisor.
  logic signed [65:0] mr, mi, nr_s, ni_s;
  logic [NW-1:0] nr_m, ni_m;
  always_comb begin
    mr   = 66'(m0_rr) - 66'(m0_ii);
    mi   = 66'(m0_ri) + 66'(m0_ir);
    nr_s = 66'(m0_rr) + 66'(m0_ii);
    ni_s = 66'(m0_ir) - 66'(m0_ri);
    nr_m = NW'(nr_s[65] ? -nr_s : nr_s) << FracBits;
    ni_m = NW'(ni_s[65] ? -ni_s : ni_s) << FracBits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s_r[0].vld <= 1'b0;
    else if (adv) s_r[0].vld <= m0_v;
    if (adv) begin
      s_r[0].func <= m0_f;
      if (m0_f == FUNC_MUL) begin
        s_r[0].sr <= 67'(mr >>> FracBits);
        s_r[0].si <= 67'(mi >>> FracBits);
      end else begin
        s_r[0].sr <= 67'(m0_ar);
        s_r[0].si <= 67'(m0_ai);
      end
      s_r[0].nr  <= nr_m;
      s_r[0].ni  <= ni_m;
      s_r[0].ngr <= nr_s[65];
      s_r[0].ngi <= ni_s[65];
      s_r[0].d   <= DW'(m0_bb) + DW'(m0_cc);
      s_r[0].qr  <= '0;
      s_r[0].qi  <= '0;
      s_r[0].ovr <= 1'b0;
      s_r[0].ovi <= 1'b0;
    end
  end

  // Stage 1 of divide: overflow test, quotient >= 2^QB means saturate.
  st_t s1_nxt;
  always_comb begin
    s1_nxt     = s_r[0];
    s1_nxt.ovr = (s_r[0].nr >> QB) >= NW'(s_r[0].d);
    s1_nxt.ovi = (s_r[0].ni >> QB) >= NW'(s_r[0].d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s_r[1].vld <= 1'b0;
    else if (adv) s_r[1] <= s1_nxt;
  end

  // Restoring division, one quotient bit per stage; remainder lives in the
  // numerator word, from which the divisor shifted to the bit is subtracted.
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    st_t           stg_nxt;
    logic          gr, gi;
    always_comb begin
      stg_nxt = s_r[k+1];
      gr = (s_r[k+1].nr >> B) >= NW'(s_r[k+1].d);
      gi = (s_r[k+1].ni >> B) >= NW'(s_r[k+1].d);
      if (gr) stg_nxt.nr = s_r[k+1].nr - (NW'(s_r[k+1].d) << B);
      if (gi) stg_nxt.ni = s_r[k+1].ni - (NW'(s_r[k+1].d) << B);
      stg_nxt.qr[B] = gr;
      stg_nxt.qi[B] = gi;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) s_r[k+2].vld <= 1'b0;
      else if (adv) s_r[k+2] <= stg_nxt;
    end
  end

  // Final: sign, saturation and status.
  localparam logic signed [31:0] MaxV = 32'sh7fffffff;
  localparam logic signed [31:0] MinV = 32'sh80000000;
  st_t l;
  logic signed [66:0] vr, vi;
  logic satr, sati;
  out_item_t res;
  always_comb begin
    l = s_r[NS-1];
    if (l.func == FUNC_DIV) begin
      vr = l.ngr ? -67'(l.qr) : 67'(l.qr);
      vi = l.ngi ? -67'(l.qi) : 67'(l.qi);
      if (l.ovr) vr = l.ngr ? -67'sd1 << 40 : 67'sd1 << 40;
      if (l.ovi) vi = l.ngi ? -67'sd1 << 40 : 67'sd1 << 40;
    end else begin
      vr = l.sr;
      vi = l.si;
    end
    satr = (vr > 67'(MaxV)) || (vr < 67'(MinV));
    sati = (vi > 67'(MaxV)) || (vi < 67'(MinV));
    res.z_re   = satr ? (vr[66] ? MinV : MaxV) : vr[31:0];
    res.z_im   = sati ? (vi[66] ? MinV : MaxV) : vi[31:0];
    res.status = (satr || sati) ? ST_SAT : ST_OK;
    if (l.func == FUNC_DIV && l.d == '0) begin
      res.z_re   = MaxV;
      res.z_im   = MaxV;
      res.status = ST_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= l.vld;
    if (adv) out_data <= res;
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> adv) else $error("pop while pipe frozen");
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DIV0 |-> out_data.z_re == MaxV)
    else $error("divide by zero value wrong");
`endif

endmodule
